// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, ignored while reset is held.
`define CHECK_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define CHECK_PROP_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/srs_pkg.sv =====
`timescale 1ns / 1ps

package srs_pkg;

    localparam int MAX_SERVERS_DEF     = 32;
    localparam int MAX_SUBREQUESTS_DEF = 64;

    localparam int OP_W     = 3;
    localparam int OFFSET_W = 48;
    localparam int SIZE_W   = 32;
    localparam int SERVER_W = 5;
    localparam int TRACE_W  = 6;
    localparam int KB_W     = 11;
    localparam int NS_W     = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 4;

    localparam logic [KB_W-1:0]   STRIDE_KB_RESET = 11'd64;
    localparam logic [KB_W-1:0]   STRIDE_KB_MAX   = 11'd1024;
    localparam logic [NS_W-1:0]   NUM_SERVERS_RESET = 6'd4;
    localparam logic [SIZE_W-1:0] META_BYTES      = 32'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_KB   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SERVERS = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN   = 3'd0,
        OP_CREATE = 3'd1,
        OP_DELETE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4
    } t_op;

    typedef struct packed {
        logic load;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic start_ok;
        logic last;
    } t_sts;

endpackage

// ===== src/stripe_request_splitter.sv =====
`timescale 1ns / 1ps
// Stripe request splitter.
// A file request (open, create, delete, read or write) enters on the s_axis
// channel and leaves as a run of sub-requests on the m_axis channel, the final
// one marked by tlast. Open gives one metadata read per server, create a
// create and a metadata write per server, delete one delete per server; read
// and write are cut into stripe-sized chunks placed round-robin on servers.
// A read or write that needs too many chunks gives one item with the error
// flag in tuser; a zero-length read or write, or an unknown kind, gives none.
// The first sub-request is shown the cycle after the request is taken, and
// the sequencer then steps one sub-request per cycle while the receiver is
// ready. A new request is taken only once the last item of the previous one
// is delivered. When the receiver stalls, the current item holds on m_axis.
// The configuration channel is always ready; write it only while idle.
// Reset restores a 64 KB stripe over four servers and drops any run in flight.

`include "assert_macros.svh"

module stripe_request_splitter #(
    parameter int MAX_SERVERS     = srs_pkg::MAX_SERVERS_DEF,
    parameter int MAX_SUBREQUESTS = srs_pkg::MAX_SUBREQUESTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, from bit 0: req_offset[47:0], req_size[79:48].
    input  logic [srs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: op[2:0].
    input  logic [srs_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, from bit 0: sub_offset[47:0], sub_size[79:48], server[84:80],
    // trace_index[90:85], zero fill[95:91].
    output logic [srs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser, from bit 0: sub_op[2:0], error[3].
    output logic [srs_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import srs_pkg::*;

    t_cmd                w_cmd;
    t_sts                w_sts;
    logic [OP_W-1:0]     w_sub_op;
    logic [OFFSET_W-1:0] w_sub_offset;
    logic [SIZE_W-1:0]   w_sub_size;
    logic [SERVER_W-1:0] w_server;
    logic [TRACE_W-1:0]  w_trace;
    logic                w_error;

    assign o_cfg_ready = 1'b1;

    srs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    srs_datapath #(
        .MAX_SERVERS     (MAX_SERVERS),
        .MAX_SUBREQUESTS (MAX_SUBREQUESTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_axis_tuser),
        .i_req_offset  (s_axis_tdata[OFFSET_W-1:0]),
        .i_req_size    (s_axis_tdata[OFFSET_W+SIZE_W-1:OFFSET_W]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_sub_op      (w_sub_op),
        .o_sub_offset  (w_sub_offset),
        .o_sub_size    (w_sub_size),
        .o_server      (w_server),
        .o_trace_index (w_trace),
        .o_last        (m_axis_tlast),
        .o_error       (w_error)
    );

    assign m_axis_tdata = {5'b0, w_trace, w_server, w_sub_size, w_sub_offset};
    assign m_axis_tuser = {w_error, w_sub_op};

    `CHECK_PROP(a_no_accept_while_busy, i_clk, i_rst_n,
        m_axis_tvalid |-> !s_axis_tready, "request accepted while a run is in progress")
    `CHECK_PROP(a_error_is_last, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser[3]) |-> m_axis_tlast, "error item not marked last")
    `CHECK_PROP(a_idle_after_last, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid,
        "output still valid after the last item of a run")

endmodule

// ===== src/srs_ctrl.sv =====
`timescale 1ns / 1ps

module srs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  srs_pkg::t_sts i_sts,
    output srs_pkg::t_cmd o_cmd
);
    import srs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = (r_state == ST_BUSY);
    assign o_cmd.load    = i_in_valid && o_in_ready;
    assign o_cmd.advance = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // Requests that yield nothing are taken and dropped here.
                if (o_cmd.load && i_sts.start_ok) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (o_cmd.advance && i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/srs_datapath.sv =====
`timescale 1ns / 1ps

module srs_datapath #(
    parameter int MAX_SERVERS     = srs_pkg::MAX_SERVERS_DEF,
    parameter int MAX_SUBREQUESTS = srs_pkg::MAX_SUBREQUESTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [srs_pkg::OP_W-1:0]       i_op,
    input  logic [srs_pkg::OFFSET_W-1:0]   i_req_offset,
    input  logic [srs_pkg::SIZE_W-1:0]     i_req_size,
    input  srs_pkg::t_cmd                  i_cmd,
    output srs_pkg::t_sts                  o_sts,
    output logic [srs_pkg::OP_W-1:0]       o_sub_op,
    output logic [srs_pkg::OFFSET_W-1:0]   o_sub_offset,
    output logic [srs_pkg::SIZE_W-1:0]     o_sub_size,
    output logic [srs_pkg::SERVER_W-1:0]   o_server,
    output logic [srs_pkg::TRACE_W-1:0]    o_trace_index,
    output logic                           o_last,
    output logic                           o_error
);
    import srs_pkg::*;

    localparam int CAP_I = (MAX_SERVERS > 32) ? 32 : MAX_SERVERS;
    localparam logic [NS_W-1:0] NS_CAP = NS_W'(CAP_I);
    localparam logic [NS_W-1:0] NS_RST = (NUM_SERVERS_RESET > NS_CAP) ? NS_CAP
                                                                       : NUM_SERVERS_RESET;
    localparam logic [SIZE_W:0] MAX_SUB = (SIZE_W+1)'(MAX_SUBREQUESTS);

    // Configuration, kept already clamped to its effective range.
    logic [KB_W-1:0] r_k;
    logic [NS_W-1:0] r_ns;

    logic [OP_W-1:0]     r_op;
    logic                r_err;
    logic                r_phase;
    logic [OFFSET_W-1:0] r_off;
    logic [SIZE_W-1:0]   r_size;
    logic [TRACE_W-1:0]  r_idx;
    logic [SERVER_W-1:0] r_srv;

    logic [KB_W-1:0]   w_cfg_k;
    logic [NS_W-1:0]   w_cfg_ns;
    logic [SIZE_W-1:0] w_stride;
    logic [SIZE_W:0]   w_limit;
    logic [SIZE_W-1:0] w_chunk;
    logic              w_rw_last;
    logic              w_idx_last;
    logic              w_in_rw;
    logic              w_in_meta;
    logic              w_srv_wrap;

    always_comb begin
        w_cfg_k = i_cfg_data;
        if (w_cfg_k == '0) begin
            w_cfg_k = KB_W'(1);
        end else if (w_cfg_k > STRIDE_KB_MAX) begin
            w_cfg_k = STRIDE_KB_MAX;
        end
        w_cfg_ns = i_cfg_data[NS_W-1:0];
        if (w_cfg_ns == '0) begin
            w_cfg_ns = NS_W'(1);
        end else if (w_cfg_ns > NS_CAP) begin
            w_cfg_ns = NS_CAP;
        end
    end

    assign w_stride   = SIZE_W'({r_k, 10'b0});
    // A request is too long when it exceeds the chunk limit times the stride.
    assign w_limit    = (SIZE_W+1)'(MAX_SUB * {1'b0, w_stride});
    assign w_chunk    = (r_size >= w_stride) ? w_stride : r_size;
    assign w_rw_last  = (r_size <= w_stride);
    assign w_idx_last = ((r_idx + TRACE_W'(1)) == TRACE_W'(r_ns));
    assign w_srv_wrap = ((NS_W'(r_srv) + NS_W'(1)) == r_ns);

    assign w_in_meta = (i_op == OP_OPEN) || (i_op == OP_CREATE) || (i_op == OP_DELETE);
    assign w_in_rw   = (i_op == OP_READ) || (i_op == OP_WRITE);
    assign o_sts.start_ok = w_in_meta || (w_in_rw && (i_req_size != '0));

    always_comb begin
        o_sub_op      = r_op;
        o_sub_offset  = r_off;
        o_sub_size    = r_size;
        o_server      = r_idx[SERVER_W-1:0];
        o_trace_index = r_idx;
        o_last        = w_idx_last;
        o_error       = 1'b0;
        if (r_err) begin
            o_server      = '0;
            o_trace_index = '0;
            o_last        = 1'b1;
            o_error       = 1'b1;
        end else begin
            case (t_op'(r_op))
                OP_OPEN: begin
                    o_sub_op     = OP_READ;
                    o_sub_offset = '0;
                    o_sub_size   = META_BYTES;
                end
                OP_CREATE: begin
                    if (r_phase) begin
                        o_sub_op      = OP_WRITE;
                        o_sub_offset  = '0;
                        o_sub_size    = META_BYTES;
                        o_trace_index = r_idx + TRACE_W'(r_ns);
                    end else begin
                        o_last = 1'b0;
                    end
                end
                OP_READ, OP_WRITE: begin
                    o_sub_size = w_chunk;
                    o_server   = r_srv;
                    o_last     = w_rw_last;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.last = o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= STRIDE_KB_RESET;
            r_ns <= NS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_STRIDE_KB) begin
                r_k <= w_cfg_k;
            end
            if (i_cfg_index == REG_NUM_SERVERS) begin
                r_ns <= w_cfg_ns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_off   <= i_req_offset;
            r_size  <= i_req_size;
            r_idx   <= '0;
            r_srv   <= '0;
            r_phase <= 1'b0;
            r_err   <= w_in_rw && ({1'b0, i_req_size} > w_limit);
        end else if (i_cmd.advance) begin
            case (t_op'(r_op))
                OP_CREATE: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_idx <= r_idx + TRACE_W'(1);
                    end
                end
                OP_READ, OP_WRITE: begin
                    r_off  <= r_off + OFFSET_W'(w_chunk);
                    r_size <= r_size - w_chunk;
                    r_idx  <= r_idx + TRACE_W'(1);
                    r_srv  <= w_srv_wrap ? '0 : r_srv + SERVER_W'(1);
                end
                default: begin
                    r_idx <= r_idx + TRACE_W'(1);
                end
            endcase
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import srs_pkg::*;

    localparam int SERVER_CAP = (MAX_SERVERS_DEF < 32) ? MAX_SERVERS_DEF : 32;
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]     sub_op;
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   nbytes;
        logic [SERVER_W-1:0] server;
        logic [TRACE_W-1:0]  trace_index;
        logic                last;
        logic                err;
    } t_subreq;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = REG_STRIDE_KB;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    // Shadow copy of the configuration registers.
    logic [KB_W-1:0] cfg_stride_kb = STRIDE_KB_RESET;
    logic [NS_W-1:0] cfg_num_servers = NUM_SERVERS_RESET;

    t_subreq     expected_subreqs[$];
    int          mismatch_count = 0;
    int          subreq_count = 0;
    int          burst_left = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_stall_en = 1'b1;
    logic [15:0] stall_pattern = '1;
    logic [3:0]  stall_phase = '0;

    stripe_request_splitter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic longint unsigned stripe_bytes();
        longint unsigned kb;
        kb = 64'(cfg_stride_kb);
        if (kb == 0) kb = 1;
        if (kb > STRIDE_KB_MAX) kb = 64'(STRIDE_KB_MAX);
        return kb * 1024;
    endfunction

    function automatic void queue_subreq(input logic [OP_W-1:0] op,
                                         input logic [OFFSET_W-1:0] off,
                                         input logic [SIZE_W-1:0] nbytes,
                                         input int server, input int trace,
                                         input bit last, input bit err);
        t_subreq s;
        s.sub_op      = op;
        s.offset      = off;
        s.nbytes      = nbytes;
        s.server      = SERVER_W'(server);
        s.trace_index = TRACE_W'(trace);
        s.last        = last;
        s.err         = err;
        expected_subreqs.insert(expected_subreqs.size(), s);
    endfunction

    // Appends the sub-requests one file request should produce and returns their count.
    function automatic int split_request(input logic [OP_W-1:0] op,
                                         input logic [OFFSET_W-1:0] off,
                                         input logic [SIZE_W-1:0] nbytes);
        int                  ns;
        longint unsigned     stride;
        longint unsigned     chunks;
        longint unsigned     remaining;
        longint unsigned     chunk;
        logic [OFFSET_W-1:0] cursor;
        int                  produced;
        ns = int'(cfg_num_servers);
        if (ns == 0) ns = 1;
        if (ns > SERVER_CAP) ns = SERVER_CAP;
        produced = 0;
        case (op)
            OP_OPEN: begin
                for (int i = 0; i < ns; i++) begin
                    queue_subreq(OP_READ, '0, META_BYTES, i, i, i + 1 == ns, 1'b0);
                    produced++;
                end
            end
            OP_CREATE: begin
                for (int i = 0; i < ns; i++) begin
                    queue_subreq(OP_CREATE, off, nbytes, i, i, 1'b0, 1'b0);
                    queue_subreq(OP_WRITE, '0, META_BYTES, i, i + ns, i + 1 == ns, 1'b0);
                    produced += 2;
                end
            end
            OP_DELETE: begin
                for (int i = 0; i < ns; i++) begin
                    queue_subreq(OP_DELETE, off, nbytes, i, i, i + 1 == ns, 1'b0);
                    produced++;
                end
            end
            OP_READ, OP_WRITE: begin
                stride    = stripe_bytes();
                remaining = 64'(nbytes);
                chunks    = (remaining + stride - 1) / stride;
                cursor    = off;
                if (chunks > MAX_SUBREQUESTS_DEF) begin
                    queue_subreq(op, off, nbytes, 0, 0, 1'b1, 1'b1);
                    produced = 1;
                end else begin
                    for (int i = 0; i < int'(chunks); i++) begin
                        chunk = (remaining >= stride) ? stride : remaining;
                        queue_subreq(op, cursor, SIZE_W'(chunk), i % ns, i,
                                     i + 1 == int'(chunks), 1'b0);
                        cursor = cursor + OFFSET_W'(chunk);
                        remaining -= chunk;
                        produced++;
                    end
                end
            end
            default: begin
                produced = 0;
            end
        endcase
        return produced;
    endfunction

    // Sink side: stall on a rotating pattern and compare each accepted item.
    always @(posedge i_clk) begin : check_subreqs
        t_subreq got;
        t_subreq want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    stall_pattern = '1;
                end else begin
                    stall_pattern = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
                end
            end
            m_axis_tready <= !sink_stall_en || stall_pattern[stall_phase];
            stall_phase = stall_phase + 1'b1;

            if (m_axis_tvalid && m_axis_tready) begin
                got.offset      = m_axis_tdata[OFFSET_W-1:0];
                got.nbytes      = m_axis_tdata[OFFSET_W +: SIZE_W];
                got.server      = m_axis_tdata[OFFSET_W + SIZE_W +: SERVER_W];
                got.trace_index = m_axis_tdata[OFFSET_W + SIZE_W + SERVER_W +: TRACE_W];
                got.sub_op      = m_axis_tuser[OP_W-1:0];
                got.err         = m_axis_tuser[OP_W];
                got.last        = m_axis_tlast;
                if (expected_subreqs.size() == 0) begin
                    log_mismatch($sformatf("sub-request %0d arrived with none expected",
                                           subreq_count));
                end else begin
                    want = expected_subreqs[0];
                    expected_subreqs.delete(0);
                    if (got !== want) begin
                        log_mismatch($sformatf({"sub-request %0d: expected op %0d off %h ",
                            "size %h server %0d trace %0d last %0b err %0b; ",
                            "got op %0d off %h size %h server %0d trace %0d last %0b err %0b"},
                            subreq_count, want.sub_op, want.offset, want.nbytes, want.server,
                            want.trace_index, want.last, want.err, got.sub_op, got.offset,
                            got.nbytes, got.server, got.trace_index, got.last, got.err));
                    end
                end
                subreq_count++;
            end
        end
    end

    // Sends one request in bursts with random gaps, then predicts its sub-requests.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [OFFSET_W-1:0] off,
                                input logic [SIZE_W-1:0] nbytes, output int produced);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (src_idle_en) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nbytes, off};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        produced = split_request(op, off, nbytes);
    endtask

    // Drains the block so that the registers can be written safely.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_subreqs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] stride_val,
                                input logic [CFG_DATA_W-1:0] servers_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_STRIDE_KB;
        i_cfg_data  <= stride_val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_stride_kb = stride_val[KB_W-1:0];
        i_cfg_index <= REG_NUM_SERVERS;
        i_cfg_data  <= servers_val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_num_servers = servers_val[NS_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    // Every kind of request under the reset stripe of 64 KB over four servers.
    task automatic test_reset_config();
        int n;
        send_request(OP_OPEN, '0, '0, n);
        send_request(OP_CREATE, '1, '1, n);
        send_request(OP_DELETE, 48'h1234_5678_9ABC, 32'd1, n);
        send_request(OP_READ, '0, 32'd1, n);
        send_request(OP_WRITE, 48'h123, 32'd327_687, n);
        send_request(OP_READ, 48'h40, '0, n);
        for (int k = 0; k < 3; k++) begin
            send_request(OP_W'(OP_UNUSED_LO + k), '0, 32'd4096, n);
        end
    endtask

    // Zero stride and zero servers fall back to 1 KB on a single server.
    task automatic test_low_extremes();
        int n;
        settle_block();
        write_config('0, '0);
        send_request(OP_READ, '0, 32'd65_536, n);
        send_request(OP_WRITE, 48'h10, 32'd65_537, n);
        send_request(OP_WRITE, 48'hFFFF_FFFF_FF9C, 32'd3000, n);
        send_request(OP_OPEN, 48'h55, 32'd77, n);
        send_request(OP_CREATE, 48'hABC, 32'd999, n);
    endtask

    // Oversized register values saturate to a 1 MB stripe over 32 servers.
    task automatic test_high_extremes();
        int n;
        settle_block();
        write_config('1, 11'd63);
        send_request(OP_OPEN, '0, '0, n);
        send_request(OP_CREATE, 48'h8000_0000_0001, 32'h8000_0001, n);
        send_request(OP_DELETE, '1, 32'd12, n);
        send_request(OP_READ, '1, '1, n);
        send_request(OP_WRITE, '0, 32'h0400_0000, n);
        send_request(OP_READ, 48'hFFFF_FFFF_FF00, 32'h0020_0005, n);
    endtask

    task automatic test_random_requests(input int n_items);
        int                  counted;
        int                  produced;
        int                  pick;
        int                  span;
        longint unsigned     stride;
        logic [OP_W-1:0]     op;
        logic [OFFSET_W-1:0] off;
        logic [SIZE_W-1:0]   nbytes;
        counted = 0;
        while (counted < n_items) begin
            stride = stripe_bytes();
            pick = $urandom_range(0, 99);
            if (pick < 5) op = OP_W'(OP_UNUSED_LO + $urandom_range(0, 2));
            else if (pick < 17) op = OP_OPEN;
            else if (pick < 29) op = OP_CREATE;
            else if (pick < 41) op = OP_DELETE;
            else if (pick < 70) op = OP_READ;
            else op = OP_WRITE;

            case ($urandom_range(0, 3))
                0: off = OFFSET_W'($urandom_range(0, 4095));
                1: off = '1 - OFFSET_W'($urandom_range(0, 1 << 22));
                default: off = {16'($urandom), 32'($urandom)};
            endcase

            if (op == OP_READ || op == OP_WRITE) begin
                case ($urandom_range(0, 9))
                    0: nbytes = '0;
                    1: nbytes = $urandom;
                    // Right around the largest run that is still split.
                    2: nbytes = SIZE_W'(MAX_SUBREQUESTS_DEF * stride +
                                        $urandom_range(0, 2) - 1);
                    default: begin
                        span = $urandom_range(1, ($urandom_range(0, 2) == 0) ? 64 : 12);
                        nbytes = SIZE_W'((span - 1) * stride +
                                         $urandom_range(1, 32'(stride)));
                    end
                endcase
            end else begin
                nbytes = $urandom;
            end

            send_request(op, off, nbytes, produced);
            counted++;
        end
    endtask

    // Phases of random requests, each under its own register setting.
    task automatic test_config_sweep();
        logic [CFG_DATA_W-1:0] stride_val;
        logic [CFG_DATA_W-1:0] servers_val;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin
                    stride_val  = 11'd1;
                    servers_val = 11'd1;
                end
                1: begin
                    stride_val  = STRIDE_KB_MAX;
                    servers_val = CFG_DATA_W'(SERVER_CAP);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: stride_val = CFG_DATA_W'($urandom_range(1, 8));
                        1: stride_val = CFG_DATA_W'($urandom_range(1, 128));
                        2: stride_val = CFG_DATA_W'($urandom_range(1000, 1100));
                        default: stride_val = CFG_DATA_W'($urandom_range(0, 2047));
                    endcase
                    // Bits above the server count field are ignored by the block.
                    if ($urandom_range(0, 1) == 0) begin
                        servers_val = CFG_DATA_W'($urandom_range(0, 8));
                    end else begin
                        servers_val = CFG_DATA_W'($urandom_range(0, 2047));
                    end
                end
            endcase
            settle_block();
            src_idle_en   = (p == 1) || (p > 1 && $urandom_range(0, 2) != 0);
            sink_stall_en = (p == 1) || (p > 1 && $urandom_range(0, 2) != 0);
            write_config(stride_val, servers_val);
            test_random_requests(56);
        end
    endtask

    initial begin : run_tests
        int wait_cycles;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_low_extremes();
        test_high_extremes();
        test_config_sweep();

        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (expected_subreqs.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_subreqs.size() != 0) begin
            log_mismatch($sformatf("%0d expected sub-requests never arrived",
                                   expected_subreqs.size()));
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
